@@ rtl/three_channel_heater_slow_pwm_defines.svh @@
// Assertion macros used by the checker file of the heater PWM block.
`ifndef THREE_CHANNEL_HEATER_SLOW_PWM_DEFINES_SVH
`define THREE_CHANNEL_HEATER_SLOW_PWM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ rtl/tcpwm_pkg.sv @@
`default_nettype none
package tcpwm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEAM_ENABLE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOTWATER_ENABLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRUDE_ENABLE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEAM_SHUTDOWN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOTWATER_SHUTDOWN = 3'd4;

   localparam logic signed [15:0] SHUTDOWN_TEMP_RESET = 16'sd2000;
   localparam logic signed [7:0]  DRIVE_MAX           = 8'sd100;
   localparam int DRIVE_W         = 7;
   localparam int EXTRUDE_SCALE   = 4;
   localparam int EXTRUDE_SHIFT   = $clog2(EXTRUDE_SCALE);
   localparam int EXTRUDE_AMT_W   = 9;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [15:0] steam_temp;
      logic signed [15:0] hotwater_temp;
      logic               steam_sensor_fault;
      logic               hotwater_sensor_fault;
      logic               water_level_block;
      logic               extrude_block;
      logic signed [7:0]  steam_drive;
      logic signed [7:0]  hotwater_drive;
      logic signed [7:0]  extrude_drive;
   } req_type;

   typedef struct packed {
      logic steam_heater_on;
      logic hotwater_heater_on;
      logic extrude_heater_on;
      logic steam_heating_active;
      logic hotwater_heating_active;
      logic steam_shutdown;
      logic hotwater_shutdown;
   } rsp_type;

   // Classified tick handed from the front to the back.
   typedef struct packed {
      logic                     steam_act;
      logic                     hotwater_act;
      logic                     extrude_act;
      logic                     steam_shut;
      logic                     hotwater_shut;
      logic [DRIVE_W-1:0]       steam_amt;
      logic [DRIVE_W-1:0]       hotwater_amt;
      logic [EXTRUDE_AMT_W-1:0] extrude_amt;
   } cmd_type;

   function automatic logic [DRIVE_W-1:0] sat_drive(input logic signed [7:0] drive);
      logic [DRIVE_W-1:0] result;
      if (drive[7]) begin
         result = '0;
      end else if (drive > DRIVE_MAX) begin
         result = DRIVE_W'(DRIVE_MAX);
      end else begin
         result = drive[DRIVE_W-1:0];
      end
      return result;
   endfunction

endpackage
`default_nettype wire

@@ rtl/tcpwm_front.sv @@
`default_nettype none
module tcpwm_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [tcpwm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tcpwm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire tcpwm_pkg::req_type                  req_word,
   output tcpwm_pkg::cmd_type                       cmd
);

   logic               steam_en_ff;
   logic               hotwater_en_ff;
   logic               extrude_en_ff;
   logic signed [15:0] steam_thr_ff;
   logic signed [15:0] hotwater_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steam_en_ff     <= 1'b0;
         hotwater_en_ff  <= 1'b0;
         extrude_en_ff   <= 1'b0;
         steam_thr_ff    <= tcpwm_pkg::SHUTDOWN_TEMP_RESET;
         hotwater_thr_ff <= tcpwm_pkg::SHUTDOWN_TEMP_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tcpwm_pkg::CSR_STEAM_ENABLE:      steam_en_ff     <= csr_wdata[0];
            tcpwm_pkg::CSR_HOTWATER_ENABLE:   hotwater_en_ff  <= csr_wdata[0];
            tcpwm_pkg::CSR_EXTRUDE_ENABLE:    extrude_en_ff   <= csr_wdata[0];
            tcpwm_pkg::CSR_STEAM_SHUTDOWN:    steam_thr_ff    <= $signed(csr_wdata);
            tcpwm_pkg::CSR_HOTWATER_SHUTDOWN: hotwater_thr_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd.steam_shut    = (req_word.steam_temp >= steam_thr_ff) || req_word.steam_sensor_fault;
      cmd.hotwater_shut = (req_word.hotwater_temp >= hotwater_thr_ff)
                          || req_word.hotwater_sensor_fault;
      cmd.steam_act     = steam_en_ff && !cmd.steam_shut && !req_word.water_level_block;
      cmd.hotwater_act  = hotwater_en_ff && !cmd.hotwater_shut;
      cmd.extrude_act   = extrude_en_ff && !req_word.extrude_block;
      cmd.steam_amt     = tcpwm_pkg::sat_drive(req_word.steam_drive);
      cmd.hotwater_amt  = tcpwm_pkg::sat_drive(req_word.hotwater_drive);
      cmd.extrude_amt   = tcpwm_pkg::EXTRUDE_AMT_W'(tcpwm_pkg::sat_drive(req_word.extrude_drive))
                          << tcpwm_pkg::EXTRUDE_SHIFT;
   end

endmodule
`default_nettype wire

@@ rtl/tcpwm_queue.sv @@
`default_nettype none
module tcpwm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tcpwm_pkg::cmd_type push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output tcpwm_pkg::cmd_type      head_cmd
);

   tcpwm_pkg::cmd_type                   entries_ff [tcpwm_pkg::QUEUE_DEPTH];
   logic [tcpwm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [tcpwm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [tcpwm_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic [tcpwm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [tcpwm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [tcpwm_pkg::QUEUE_CNT_W-1:0]    count_in;

   assign full       = (count_ff == tcpwm_pkg::QUEUE_CNT_W'(tcpwm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tcpwm_pkg::QUEUE_PTR_W'(tcpwm_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tcpwm_pkg::QUEUE_PTR_W'(tcpwm_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tcpwm_chan.sv @@
`default_nettype none
module tcpwm_chan #(
   parameter int PERIOD = 100,
   parameter int AW     = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic          act,
   input  wire logic [AW-1:0] amount,
   output logic               level_next
);

   localparam int CW = $clog2(PERIOD + 1);
   localparam int XW = ((CW > AW) ? CW : AW) + 1;
   localparam logic [CW-1:0] PERIOD_C = CW'(PERIOD);
   localparam logic [XW-1:0] PERIOD_X = XW'(PERIOD);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] on_at_ff;
   logic [CW-1:0] on_at_in;
   logic          level_ff;
   logic [XW-1:0] amount_x;

   assign amount_x = XW'(amount);

   always_comb begin
      count_in   = count_ff;
      on_at_in   = on_at_ff;
      level_next = 1'b0;
      if (act) begin
         level_next = level_ff || (count_ff == on_at_ff);
         if (count_ff < PERIOD_C) begin
            count_in = count_ff + 1'b1;
         end else begin
            // Period end: drop the output and load the next on-time compare.
            level_next = 1'b0;
            count_in   = '0;
            on_at_in   = (amount_x >= PERIOD_X) ? '0 : CW'(PERIOD_X - amount_x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         on_at_ff <= '0;
         level_ff <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         on_at_ff <= on_at_in;
         level_ff <= level_next;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tcpwm_back.sv @@
`default_nettype none
module tcpwm_back #(
   parameter int SHORT_PERIOD = 100,
   parameter int LONG_PERIOD  = 400
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   input  wire tcpwm_pkg::cmd_type cmd,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output tcpwm_pkg::rsp_type      rsp_word
);

   logic               rsp_valid_ff;
   tcpwm_pkg::rsp_type rsp_word_ff;
   tcpwm_pkg::rsp_type rsp_word_in;
   logic               steam_lvl;
   logic               hotwater_lvl;
   logic               extrude_lvl;

   // A word moves on when the output register is empty or is being taken.
   assign cmd_pop = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   tcpwm_chan #(.PERIOD(SHORT_PERIOD), .AW(tcpwm_pkg::DRIVE_W)) u_steam (
      .clock      (clock),
      .reset      (reset),
      .step       (cmd_pop),
      .act        (cmd.steam_act),
      .amount     (cmd.steam_amt),
      .level_next (steam_lvl)
   );

   tcpwm_chan #(.PERIOD(SHORT_PERIOD), .AW(tcpwm_pkg::DRIVE_W)) u_hotwater (
      .clock      (clock),
      .reset      (reset),
      .step       (cmd_pop),
      .act        (cmd.hotwater_act),
      .amount     (cmd.hotwater_amt),
      .level_next (hotwater_lvl)
   );

   tcpwm_chan #(.PERIOD(LONG_PERIOD), .AW(tcpwm_pkg::EXTRUDE_AMT_W)) u_extrude (
      .clock      (clock),
      .reset      (reset),
      .step       (cmd_pop),
      .act        (cmd.extrude_act),
      .amount     (cmd.extrude_amt),
      .level_next (extrude_lvl)
   );

   always_comb begin
      rsp_word_in.steam_heater_on         = steam_lvl;
      rsp_word_in.hotwater_heater_on      = hotwater_lvl;
      rsp_word_in.extrude_heater_on       = extrude_lvl;
      rsp_word_in.steam_heating_active    = cmd.steam_act;
      rsp_word_in.hotwater_heating_active = cmd.hotwater_act;
      rsp_word_in.steam_shutdown          = cmd.steam_shut;
      rsp_word_in.hotwater_shutdown       = cmd.hotwater_shut;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

@@ rtl/three_channel_heater_slow_pwm.sv @@
// An accepted word enters the queue; its result is registered at the output when popped.
// One word per cycle unless the output stalls; channel counters step once per popped word.
// A two-word queue separates the input classification from the channel update.
// Reset (synchronous, active high) clears all counters, compares, heater levels and the queue,
// disables all three channels and sets both shutdown thresholds to 2000.
`default_nettype none
module three_channel_heater_slow_pwm #(
   parameter int SHORT_PERIOD = 100,
   parameter int LONG_PERIOD  = 400
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_en,
   input  wire logic [tcpwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tcpwm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire tcpwm_pkg::req_type                req_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output tcpwm_pkg::rsp_type                     rsp_word
);

   tcpwm_pkg::cmd_type front_cmd;
   tcpwm_pkg::cmd_type head_cmd;
   logic               queue_full;
   logic               head_valid;
   logic               cmd_pop;
   logic               push;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   tcpwm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_word     (req_word),
      .cmd          (front_cmd)
   );

   tcpwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tcpwm_back #(.SHORT_PERIOD(SHORT_PERIOD), .LONG_PERIOD(LONG_PERIOD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

@@ rtl/tcpwm_checker.sv @@
`default_nettype none
`include "three_channel_heater_slow_pwm_defines.svh"
module tcpwm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              csr_write_en,
   input wire logic [tcpwm_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [tcpwm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire tcpwm_pkg::req_type                req_word,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire tcpwm_pkg::rsp_type                rsp_word
);

   // A result word waiting on the output holds its value.
   `TCPWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // The steam and hot-water relays can only be on while their channel is heating.
   `TCPWM_ASSERT_SAME(a_steam_on_active, clock, reset, rsp_valid && rsp_word.steam_heater_on, rsp_word.steam_heating_active)

   `TCPWM_ASSERT_SAME(a_hotwater_on_active, clock, reset, rsp_valid && rsp_word.hotwater_heater_on, rsp_word.hotwater_heating_active)

   // A shut-down steam channel never reports itself as heating.
   `TCPWM_ASSERT_SAME(a_steam_shut_idle, clock, reset, rsp_valid && rsp_word.steam_shutdown, !rsp_word.steam_heating_active)

endmodule

bind three_channel_heater_slow_pwm tcpwm_checker u_checker (.*);
`default_nettype wire
